>>> hw/rtl/awi_pkg.sv
`default_nettype none
package awi_pkg;

  // Table geometry and harmonic count
  localparam int TABLE_LEN     = 1024;
  localparam int ROM_LEN       = TABLE_LEN - 1;
  localparam int NUM_HARMONICS = 8;
  localparam int ADDR_W        = $clog2(TABLE_LEN);
  localparam int PHASE_W       = $clog2(ROM_LEN);
  localparam int HARM_W        = $clog2(NUM_HARMONICS);

  // Port widths
  localparam int POS_W    = 26;
  localparam int FRAC_W   = 16;
  localparam int AMP_W    = 16;
  localparam int SINE_W   = 16;
  localparam int SAMPLE_W = 19;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W   = AMP_W + SINE_W;

  // Amplitude reset values
  localparam logic signed [AMP_W-1:0] AMP_H1_RESET = 16'sd32767;

  // Pi in Q40
  localparam logic [63:0] PI_Q40 = 64'd3454217652358;

  typedef logic [ADDR_W-1:0]          tbl_addr_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic signed [AMP_W-1:0]    amp_t;
  typedef logic signed [SINE_W-1:0]   sine_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sine_t                      sine_rom_t [ROM_LEN];

  // Write request from the table builder to the wave table
  typedef struct packed {
    logic      en;
    tbl_addr_t addr;
    sample_t   data;
  } awi_wr_t;

  // Sine of 2*pi*p/ROM_LEN scaled to 32767, Q31 Taylor series
  function automatic sine_t sine_value(input int unsigned p);
    logic [63:0]        q;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    logic [63:0]        mag;
    logic               neg;
    neg = 1'b0;
    q = 64'(2 * p);
    if (q >= 64'(ROM_LEN)) begin
      neg = 1'b1;
      q = q - 64'(ROM_LEN);
    end
    if ((q << 1) > 64'(ROM_LEN)) begin
      q = 64'(ROM_LEN) - q;
    end
    x = (PI_Q40 * q) / ROM_LEN;
    x = (x + 64'd256) >> 9;
    x2 = (x * x) >> 31;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 31) / 6;   sum = sum - $signed(term);
    term = ((term * x2) >> 31) / 20;  sum = sum + $signed(term);
    term = ((term * x2) >> 31) / 42;  sum = sum - $signed(term);
    term = ((term * x2) >> 31) / 72;  sum = sum + $signed(term);
    term = ((term * x2) >> 31) / 110; sum = sum - $signed(term);
    term = ((term * x2) >> 31) / 156; sum = sum + $signed(term);
    term = ((term * x2) >> 31) / 210; sum = sum - $signed(term);
    term = ((term * x2) >> 31) / 272; sum = sum + $signed(term);
    term = ((term * x2) >> 31) / 342; sum = sum - $signed(term);
    term = ((term * x2) >> 31) / 420; sum = sum + $signed(term);
    s = (sum < 0) ? 64'd0 : 64'(sum);
    mag = (64'd32767 * s + (64'd1 << 30)) >> 31;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return neg ? -sine_t'(mag[SINE_W-1:0]) : sine_t'(mag[SINE_W-1:0]);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k < ROM_LEN; k++) begin
      rom[k] = sine_value(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

>>> hw/rtl/awi_builder.sv
`default_nettype none
module awi_builder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [awi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [awi_pkg::AMP_W-1:0]        cfg_wdata,
  output awi_pkg::awi_wr_t                      wr,
  output logic                                  busy
);
  import awi_pkg::*;

  localparam logic [HARM_W-1:0] HARM_LAST = HARM_W'(NUM_HARMONICS - 1);
  localparam tbl_addr_t         IDX_LAST  = ADDR_W'(TABLE_LEN - 1);
  localparam phase_t            PHASE_TOP = PHASE_W'(ROM_LEN - 1);

  logic      cfg_hit;
  amp_t      amp_r [NUM_HARMONICS];

  // Sequencer: entry index, harmonic, phase (h+1)*i mod ROM_LEN, stride i mod ROM_LEN
  logic              run_r;
  tbl_addr_t         idx_r;
  logic [HARM_W-1:0] harm_r;
  phase_t            phase_r;
  phase_t            stride_r;
  logic [PHASE_W:0]  phase_sum;
  phase_t            phase_nxt;
  phase_t            stride_nxt;

  // Stage 1: sine ROM read and amplitude select
  logic              v1_r;
  logic [HARM_W-1:0] h1_r;
  tbl_addr_t         i1_r;
  sine_t             sine_r;
  amp_t              amp_q_r;

  // Stage 2: product
  logic                     v2_r;
  logic [HARM_W-1:0]        h2_r;
  tbl_addr_t                i2_r;
  logic signed [PROD_W-1:0] prod_r;

  // Stage 3: accumulate
  sample_t                  acc_r;
  sample_t                  acc_nxt;
  logic signed [PROD_W-16:0] term;

  assign cfg_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_HARMONICS));

  // Hold amplitude registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_HARMONICS; k++) begin
        amp_r[k] <= (k == 0) ? AMP_H1_RESET : '0;
      end
    end else if (cfg_hit) begin
      amp_r[cfg_index[HARM_W-1:0]] <= cfg_wdata;
    end
  end

  // Advance phase by the stride, one wrap at most
  always_comb begin
    phase_sum = {1'b0, phase_r} + {1'b0, stride_r};
    if (phase_sum >= (PHASE_W+1)'(ROM_LEN)) begin
      phase_nxt = PHASE_W'(phase_sum - (PHASE_W+1)'(ROM_LEN));
    end else begin
      phase_nxt = phase_sum[PHASE_W-1:0];
    end
    stride_nxt = (stride_r == PHASE_TOP) ? '0 : stride_r + 1'b1;
  end

  // Walk every entry and harmonic; restart on an amplitude write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      run_r    <= 1'b1;
      idx_r    <= '0;
      harm_r   <= '0;
      phase_r  <= '0;
      stride_r <= '0;
    end else if (run_r) begin
      if (harm_r == HARM_LAST) begin
        harm_r   <= '0;
        idx_r    <= idx_r + 1'b1;
        stride_r <= stride_nxt;
        phase_r  <= stride_nxt;
        if (idx_r == IDX_LAST) begin
          run_r <= 1'b0;
        end
      end else begin
        harm_r  <= harm_r + 1'b1;
        phase_r <= phase_nxt;
      end
    end
  end

  // Read sine ROM and pick amplitude
  always_ff @(posedge clk) begin
    sine_r  <= SINE_ROM[phase_r];
    amp_q_r <= amp_r[harm_r];
    h1_r    <= harm_r;
    i1_r    <= idx_r;
    prod_r  <= amp_q_r * sine_r;
    h2_r    <= h1_r;
    i2_r    <= i1_r;
    acc_r   <= acc_nxt;
  end

  // Pipeline valid flags; drop work in flight on restart
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= run_r;
      v2_r <= v1_r;
    end
  end

  // Accumulate floor(prod / 2^15) across harmonics
  always_comb begin
    term    = prod_r[PROD_W-1:15];
    acc_nxt = ((h2_r == '0) ? sample_t'(0) : acc_r) + SAMPLE_W'(term);
  end

  assign wr.en   = v2_r && (h2_r == HARM_LAST);
  assign wr.addr = i2_r;
  assign wr.data = acc_nxt;

  assign busy = run_r || v1_r || v2_r;

endmodule
`default_nettype wire

>>> hw/rtl/additive_wavetable_interpolated_lookup.sv
`default_nettype none
// Additive wavetable oscillator lookup. The wave table (1024 entries) is built from
// eight harmonic amplitudes: after reset is released, and from the cycle of an amplitude
// write (cfg_index 0..7) until the table is rebuilt, busy stays high while one
// multiply-accumulate per cycle fills the table; writes to other indexes are ignored but
// still hold busy for their own cycle. While busy is low an item is transferred on every
// cycle that start is high, so one position per clock is sustained; the two table reads
// go through the two read ports of the table memory in the same cycle. Each result
// appears on out_sample_out with out_valid high for one cycle, after the table read,
// weighted product and output registers, in order; the receiver cannot stall the output.
module additive_wavetable_interpolated_lookup (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [awi_pkg::POS_W-1:0]      in_read_position,
  output logic                                out_valid,
  output logic signed [awi_pkg::SAMPLE_W-1:0] out_sample_out,
  input  wire logic                           cfg_we,
  input  wire logic [awi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [awi_pkg::AMP_W-1:0]      cfg_wdata
);
  import awi_pkg::*;

  localparam int WGT_W = FRAC_W + 1;
  localparam int MUL_W = SAMPLE_W + WGT_W + 1;
  localparam int SUM_W = MUL_W + 1;
  localparam tbl_addr_t IDX_LAST = ADDR_W'(TABLE_LEN - 1);

  awi_wr_t   wr;
  logic      build_busy;
  logic      accept;
  tbl_addr_t lo;
  tbl_addr_t hi;

  sample_t wave_mem [TABLE_LEN];

  // Stage 1: table read data
  logic              s1_v_r;
  logic [FRAC_W-1:0] frac_r;
  sample_t           t_lo_r;
  sample_t           t_hi_r;
  logic [WGT_W-1:0]  w_lo;
  logic [WGT_W-1:0]  w_hi;

  // Stage 2: weighted products
  logic                    s2_v_r;
  logic signed [MUL_W-1:0] prod_lo_r;
  logic signed [MUL_W-1:0] prod_hi_r;
  logic signed [SUM_W-1:0] sum;

  // Stage 3: output register
  logic    out_valid_r;
  sample_t out_sample_r;

  awi_builder u_builder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .wr        (wr),
    .busy      (build_busy)
  );

  assign busy   = build_busy || cfg_we;
  assign accept = start && !busy;

  // Neighbor indexes, wrapping past the last entry
  assign lo = in_read_position[FRAC_W +: ADDR_W];
  assign hi = (lo == IDX_LAST) ? '0 : lo + 1'b1;

  // Wave table: one write port for the builder, two read ports for lookup
  always_ff @(posedge clk) begin
    if (wr.en) begin
      wave_mem[wr.addr] <= wr.data;
    end
    t_lo_r <= wave_mem[lo];
    t_hi_r <= wave_mem[hi];
    frac_r <= in_read_position[FRAC_W-1:0];
  end

  // Weight both neighbors
  assign w_hi = {1'b0, frac_r};
  assign w_lo = (WGT_W'(1) << FRAC_W) - w_hi;

  always_ff @(posedge clk) begin
    prod_lo_r <= t_lo_r * $signed({1'b0, w_lo});
    prod_hi_r <= t_hi_r * $signed({1'b0, w_hi});
  end

  // Round and take the floor shift
  assign sum = SUM_W'(prod_lo_r) + SUM_W'(prod_hi_r) + (SUM_W'(1) <<< (FRAC_W - 1));

  always_ff @(posedge clk) begin
    out_sample_r <= sum[FRAC_W +: SAMPLE_W];
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= accept;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule
`default_nettype wire
